### rtl/core/blfp_pkg.sv
`default_nettype none

package blfp_pkg;

   // Field and register widths.
   localparam int PIN_W        = 12;
   localparam int DIV_FACTOR_W = 3;
   localparam int MV_W         = 14;
   localparam int PCT_W        = 8;
   localparam int LEVEL_W      = 22;
   localparam int SCALED_W     = 15;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 14;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 24;

   // Discharge curve of one LiPo cell.
   localparam int CURVE_POINTS = 11;
   localparam int CURVE_IDX_W  = 4;
   localparam int CURVE_MV_W   = 13;
   localparam int CURVE_PCT_W  = 7;

   localparam logic [CURVE_MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
      13'd3450, 13'd3680, 13'd3740, 13'd3770, 13'd3790, 13'd3820,
      13'd3870, 13'd3920, 13'd3980, 13'd4060, 13'd4200
   };
   localparam logic [CURVE_PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
      7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
   };

   localparam logic [CURVE_MV_W-1:0]  EMPTY_LEVEL_MV = 13'd100;
   localparam logic [MV_W-1:0]        MV_MAX         = 14'd16383;
   localparam logic [CURVE_PCT_W-1:0] PCT_FULL       = 7'd100;
   localparam logic [CURVE_PCT_W-1:0] PCT_EMPTY      = 7'd0;
   localparam logic signed [PCT_W-1:0] PCT_INVALID   = -8'sd1;

   // Register reset values.
   localparam logic                    PRESENT_RESET = 1'b1;
   localparam logic [DIV_FACTOR_W-1:0] DIVIDER_RESET = 3'd2;
   localparam logic [MV_W-1:0]         UPPER_RESET   = 14'd4300;
   localparam logic [MV_W-1:0]         LOWER_RESET   = 14'd2500;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PRESENT = 2'd0,
      CSR_DIVIDER = 2'd1,
      CSR_UPPER   = 2'd2,
      CSR_LOWER   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                    present;
      logic [DIV_FACTOR_W-1:0] divider;
      logic [MV_W-1:0]         upper;
      logic [MV_W-1:0]         lower;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       filter;
      logic       segment;
      logic       div_step;
      logic [1:0] div_bit;
      logic       out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic early_exit;
   } dp_status_type;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_CHECK   = 5'b00010,
      ST_SEGMENT = 5'b00100,
      ST_DIVIDE  = 5'b01000,
      ST_DONE    = 5'b10000
   } ctrl_state_type;

endpackage

`default_nettype wire

### rtl/core/blfp_ctrl.sv
`default_nettype none

module blfp_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output blfp_pkg::dp_cmd_type   cmd,
   input  blfp_pkg::dp_status_type status
);
   import blfp_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic [1:0]     div_cnt_ff, div_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // The output register is free when empty or drained in this cycle.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Next state and datapath commands.
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      cmd.div_bit = div_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.filter = 1'b1;
            state_in   = status.early_exit ? ST_DONE : ST_SEGMENT;
         end
         ST_SEGMENT: begin
            cmd.segment = 1'b1;
            div_cnt_in  = 2'd3;
            state_in    = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff - 2'd1;
            if (div_cnt_ff == 2'd0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag of the output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/blfp_datapath.sv
`default_nettype none

module blfp_datapath #(
   parameter int FRACTION_BITS = 8
) (
   input  wire                           clock,
   input  wire                           reset,
   input  blfp_pkg::cfg_type             cfg,
   input  wire  [blfp_pkg::PIN_W-1:0]    pin_mv,
   input  blfp_pkg::dp_cmd_type          cmd,
   output blfp_pkg::dp_status_type       status,
   output logic                          reading_valid,
   output logic [blfp_pkg::MV_W-1:0]     battery_mv,
   output logic signed [blfp_pkg::PCT_W-1:0] charge_percent
);
   import blfp_pkg::*;

   // Divider operands: a segment spans at most 255 mV before scaling.
   localparam int DIV_W = 14 + FRACTION_BITS;

   logic [SCALED_W-1:0]    scaled_ff;
   logic [LEVEL_W-1:0]     level_ff, level_in;
   logic                   have_ff, have_in;
   logic                   invalid_ff, invalid_in;
   logic [DIV_W-1:0]       num_ff, num_in;
   logic [DIV_W-1:0]       den2_ff, den2_in;
   logic [3:0]             quot_ff, quot_in;
   logic [CURVE_PCT_W-1:0] base_pct_ff, base_pct_in;
   logic                   out_valid_ff;
   logic [MV_W-1:0]        out_mv_ff;
   logic signed [PCT_W-1:0] out_pct_ff;

   logic                   in_window;
   logic [LEVEL_W-1:0]     sample;
   logic [LEVEL_W+2:0]     ema_sum;
   logic                   empty_level;
   logic [LEVEL_W-1:0]     thr [CURVE_POINTS];
   logic [CURVE_IDX_W-1:0] seg_idx;
   logic [DIV_W-1:0]       seg_offset;
   logic [DIV_W-1:0]       seg_span;
   logic [DIV_W-1:0]       trial;
   logic [LEVEL_W:0]       mv_sum;
   logic [LEVEL_W:0]       mv_full;
   logic [MV_W-1:0]        mv_round;
   logic [CURVE_PCT_W-1:0] pct_sum;

   // Window check and exponential average with alpha one quarter.
   assign in_window = (scaled_ff <= SCALED_W'(cfg.upper)) &&
                      (scaled_ff >= SCALED_W'(cfg.lower));
   assign status.early_exit = !cfg.present || !in_window;
   assign sample  = LEVEL_W'(scaled_ff[MV_W-1:0]) << FRACTION_BITS;
   assign ema_sum = (LEVEL_W+3)'(level_ff) + (LEVEL_W+3)'({level_ff, 1'b0}) +
                    (LEVEL_W+3)'(sample) + (LEVEL_W+3)'(2);

   always_comb begin
      level_in   = level_ff;
      have_in    = have_ff;
      invalid_in = invalid_ff;
      if (cmd.filter) begin
         invalid_in = status.early_exit;
         if (cfg.present) begin
            if (!in_window) begin
               have_in = 1'b0;
            end else begin
               have_in  = 1'b1;
               level_in = have_ff ? ema_sum[LEVEL_W+1:2] : sample;
            end
         end
      end else if (cmd.segment) begin
         invalid_in = invalid_ff || empty_level;
      end
   end

   assign empty_level = (level_ff <= (LEVEL_W'(EMPTY_LEVEL_MV) << FRACTION_BITS));

   // Curve breakpoints in the fixed point of the filter.
   always_comb begin
      for (int i = 0; i < CURVE_POINTS; i++) begin
         thr[i] = LEVEL_W'(CURVE_MV[i]) << FRACTION_BITS;
      end
   end

   // Segment lookup: the first breakpoint at or above the level.
   always_comb begin
      seg_idx = CURVE_IDX_W'(CURVE_POINTS - 1);
      for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
         if (level_ff <= thr[i]) begin
            seg_idx = CURVE_IDX_W'(i);
         end
      end
   end

   // Divider setup: quotient of (20*offset + span) / (2*span) rounds half up.
   always_comb begin
      base_pct_in = base_pct_ff;
      num_in      = num_ff;
      den2_in     = den2_ff;
      quot_in     = quot_ff;
      seg_offset  = '0;
      seg_span    = DIV_W'(1);
      if (level_ff <= thr[0]) begin
         base_pct_in = PCT_EMPTY;
      end else if (level_ff >= thr[CURVE_POINTS-1]) begin
         base_pct_in = PCT_FULL;
      end else begin
         base_pct_in = CURVE_PCT[seg_idx - CURVE_IDX_W'(1)];
         seg_offset  = DIV_W'(level_ff - thr[seg_idx - CURVE_IDX_W'(1)]);
         seg_span    = DIV_W'(thr[seg_idx] - thr[seg_idx - CURVE_IDX_W'(1)]);
      end
      if (cmd.segment) begin
         num_in  = (seg_offset << 4) + (seg_offset << 2) + seg_span;
         den2_in = seg_span << 1;
         quot_in = 4'd0;
      end else begin
         base_pct_in = base_pct_ff;
         if (cmd.div_step && (num_ff >= trial)) begin
            num_in = num_ff - trial;
            quot_in[cmd.div_bit] = 1'b1;
         end
      end
   end

   // One restoring step per cycle, most significant quotient bit first.
   assign trial = den2_ff << cmd.div_bit;

   // Filtered millivolts, rounded half up and clamped.
   assign mv_sum   = (LEVEL_W+1)'(level_ff) + ((LEVEL_W+1)'(1) << (FRACTION_BITS - 1));
   assign mv_full  = mv_sum >> FRACTION_BITS;
   assign mv_round = (mv_full > (LEVEL_W+1)'(MV_MAX)) ? MV_MAX : mv_full[MV_W-1:0];
   assign pct_sum  = base_pct_ff + CURVE_PCT_W'(quot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         have_ff  <= 1'b0;
      end else begin
         level_ff <= level_in;
         have_ff  <= have_in;
      end
   end

   // Working registers and the output register.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scaled_ff <= SCALED_W'(pin_mv) * SCALED_W'(cfg.divider);
      end
      invalid_ff  <= invalid_in;
      num_ff      <= num_in;
      den2_ff     <= den2_in;
      quot_ff     <= quot_in;
      base_pct_ff <= base_pct_in;
      if (cmd.out_load) begin
         out_valid_ff <= !invalid_ff;
         out_mv_ff    <= invalid_ff ? '0 : mv_round;
         out_pct_ff   <= invalid_ff ? PCT_INVALID : PCT_W'(signed'({1'b0, pct_sum}));
      end
   end

   assign reading_valid  = out_valid_ff;
   assign battery_mv     = out_mv_ff;
   assign charge_percent = out_pct_ff;

endmodule

`default_nettype wire

### rtl/core/battery_level_filter_to_percent_unit.sv
// Battery level filter and state-of-charge estimator for one LiPo cell. Each
// req transaction carries one pin reading in millivolts; each one yields exactly
// one rsp transaction with the validity flag, the filtered battery voltage and
// the charge in percent (-1 when invalid). The reading is scaled at the edge that
// accepts it; a reading inside the window then passes through the filter update,
// the curve segment lookup, four steps of the radix-2 restoring divider that
// interpolates inside the segment, and the output load. An absent battery or a
// reading outside the window goes from the filter check straight to the output
// load. The controller handles one reading at a time; a new reading is accepted
// as soon as the previous result sits in the output register, even while that
// result still waits for rsp_tready. The output load waits while the output
// register still holds an undrained result. The user must write registers through
// the csr port only while no reading is in flight; the block does not enforce it.
`default_nettype none

module battery_level_filter_to_percent_unit #(
   parameter int FRACTION_BITS = 8
) (
   input  wire                                  clock,
   input  wire                                  reset,
   // req_tdata: pin_mv [11:0], zero [15:12]
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire  [blfp_pkg::REQ_DATA_W-1:0]      req_tdata,
   // rsp_tdata: reading_valid [0], battery_mv [14:1], charge_percent [22:15], zero [23]
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [blfp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  wire                                  csr_we,
   input  wire  [blfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire  [blfp_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import blfp_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   dp_cmd_type    cmd;
   dp_status_type status;
   logic          reading_valid;
   logic [MV_W-1:0] battery_mv;
   logic signed [PCT_W-1:0] charge_percent;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PRESENT: cfg_in.present = csr_wdata[0];
            CSR_DIVIDER: cfg_in.divider = csr_wdata[DIV_FACTOR_W-1:0];
            CSR_UPPER:   cfg_in.upper   = csr_wdata[MV_W-1:0];
            CSR_LOWER:   cfg_in.lower   = csr_wdata[MV_W-1:0];
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.present <= PRESENT_RESET;
         cfg_ff.divider <= DIVIDER_RESET;
         cfg_ff.upper   <= UPPER_RESET;
         cfg_ff.lower   <= LOWER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   blfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   blfp_datapath #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .pin_mv         (req_tdata[PIN_W-1:0]),
      .cmd            (cmd),
      .status         (status),
      .reading_valid  (reading_valid),
      .battery_mv     (battery_mv),
      .charge_percent (charge_percent)
   );

   // Pack the result fields from the lowest bit up.
   assign rsp_tdata = {1'b0, charge_percent, battery_mv, reading_valid};

endmodule

`default_nettype wire

### rtl/core/blfp_checker.sv
`default_nettype none

module blfp_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [23:0] rsp_tdata
);

   // A stalled result holds its data.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp data changed while stalled");

   // An invalid reading reports zero millivolts and minus one percent.
   a_invalid_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[14:1] == 14'd0 &&
                                      rsp_tdata[22:15] == 8'hFF)
      else $error("invalid result with nonzero fields");

   // A valid reading has a percent in 0..100 and a level that rounds to at least
   // the empty mark.
   a_valid_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[22:15] <= 8'd100 &&
                                     rsp_tdata[14:1] >= 14'd100)
      else $error("valid result out of range");

   // The block takes one reading at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Reset leaves no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind battery_level_filter_to_percent_unit blfp_checker u_blfp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
